// ===== rtl/mrpt_pkg.sv =====
// Shared types and constants for the Miller-Rabin prime test block.
package mrpt_pkg;

	localparam int BaseTableSize = 11;
	localparam int BaseWidth = 5;

	function automatic logic [BaseWidth-1:0] base_at(input logic [3:0] idx);
		logic [BaseWidth-1:0] b;
		begin
			case (idx)
				4'd0: b = 5'd2;
				4'd1: b = 5'd3;
				4'd2: b = 5'd5;
				4'd3: b = 5'd7;
				4'd4: b = 5'd11;
				4'd5: b = 5'd13;
				4'd6: b = 5'd17;
				4'd7: b = 5'd19;
				4'd8: b = 5'd23;
				4'd9: b = 5'd29;
				4'd10: b = 5'd31;
				default: b = 5'd2;
			endcase
			return b;
		end
	endfunction

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mm_ctl_t;

endpackage

// ===== rtl/mrpt_mulmod.sv =====
// Bit-serial modular multiplier: (a * b) mod m, one multiplier bit per cycle.
module mrpt_mulmod
	import mrpt_pkg::*;
#(
	parameter int W = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic [W-1:0] p,
	output mm_ctl_t      ctl
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q, b_q, m_q, acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    dbl, dred, add, ared;

	always_comb begin
		dbl  = {acc_q, 1'b0};
		dred = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		add  = dred + {1'b0, a_q};
		if (b_q[W-1]) begin
			ared = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
		end else begin
			ared = dred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= ared[W-1:0];
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign p = acc_q;
	assign ctl = '{start: start, busy: busy_q, done: done_q};
endmodule

// ===== rtl/miller_rabin_prime_test.sv =====
// Top level: Miller-Rabin sequencer around a shared modular multiplier.
// Usage: present a candidate with in_valid; it is accepted when in_stall is
// low. The block then works alone on that item and holds in_stall high until
// the result item has been taken on the output channel.
// Every modular product runs on one bit-serial multiply-reduce unit. Per base,
// base^d costs up to two products per bit of d and the squaring chain r-1
// more; d has at most VALUE_WIDTH-r bits, so a 63-bit prime needs at most
// 124 products per base.
// Values below 2 and the small primes 2..31 go from S_SHIFT straight to S_OUT
// without using the multiplier. An even candidate fails on the first base,
// after up to 126 products.
// is_prime appears with out_valid and is held while out_stall is high; the
// next candidate can be taken once the block is back in S_IDLE after the
// result item leaves.
// Reset (arst_n low) drops any item in flight and returns to idle.
module miller_rabin_prime_test
	import mrpt_pkg::*;
#(
	parameter int NUM_BASES   = 11,
	parameter int VALUE_WIDTH = 63
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   is_prime
);
	localparam int W  = VALUE_WIDTH;
	localparam int RW = $clog2(W + 1);
	localparam logic [3:0] LastBase = 4'(NUM_BASES - 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SHIFT = 9'b000000010,
		S_BASE  = 9'b000000100,
		S_POW   = 9'b000001000,
		S_PWAIT = 9'b000010000,
		S_CHECK = 9'b000100000,
		S_SQ    = 9'b001000000,
		S_SWAIT = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t        state_q;
	logic [W-1:0]  x_q, d_q, e_q, res_q, sq_q;
	logic [RW-1:0] r_q, j_q;
	logic [3:0]    bi_q;
	logic          mul_res_q, prime_q;
	logic [W-1:0]  xm1;
	logic          small_hit;

	logic          mm_start;
	logic [W-1:0]  mm_a, mm_b, mm_p;
	mm_ctl_t       mm_ctl;

	assign xm1 = x_q - W'(1);

	always_comb begin
		small_hit = 1'b0;
		for (int i = 0; i < BaseTableSize; i++) begin
			if (x_q == W'(base_at(4'(i)))) small_hit = 1'b1;
		end
	end

	mrpt_mulmod #(.W(W)) u_mm (
		.clk(clk), .arst_n(arst_n), .start(mm_start),
		.a(mm_a), .b(mm_b), .m(x_q), .p(mm_p), .ctl(mm_ctl)
	);

	always_comb begin
		mm_start = 1'b0;
		mm_a = sq_q;
		mm_b = sq_q;
		if (state_q == S_POW && e_q != '0) begin
			mm_start = 1'b1;
			if (e_q[0] && !mul_res_q) mm_b = res_q;
		end else if (state_q == S_SQ) begin
			mm_start = 1'b1;
			mm_a = res_q;
			mm_b = res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mul_res_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SHIFT;
				S_SHIFT: begin
					if (x_q < W'(2)) begin
						prime_q <= 1'b0;
						state_q <= S_OUT;
					end else if (small_hit) begin
						prime_q <= 1'b1;
						state_q <= S_OUT;
					end else if (d_q != '0 && !d_q[0]) begin
						d_q <= d_q >> 1;
						r_q <= r_q + 1'b1;
					end else begin
						bi_q    <= '0;
						prime_q <= 1'b1;
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					e_q       <= d_q;
					res_q     <= W'(1);
					// base 2 comes first and settles every composite below 32
					sq_q      <= W'(base_at(bi_q));
					mul_res_q <= 1'b0;
					state_q   <= S_POW;
				end
				S_POW: begin
					if (e_q == '0) begin
						j_q     <= '0;
						state_q <= S_CHECK;
					end else begin
						state_q <= S_PWAIT;
					end
				end
				S_PWAIT: if (mm_ctl.done) begin
					// odd exponent bit: multiply result first, then square
					if (e_q[0] && !mul_res_q) begin
						res_q     <= mm_p;
						mul_res_q <= 1'b1;
					end else begin
						sq_q      <= mm_p;
						e_q       <= e_q >> 1;
						mul_res_q <= 1'b0;
					end
					state_q <= S_POW;
				end
				S_CHECK: begin
					// a 1 passes only as base^d itself, never after squaring
					if ((j_q == '0 && res_q == W'(1)) || (j_q < r_q && res_q == xm1)) begin
						if (bi_q == LastBase) state_q <= S_OUT;
						else begin
							bi_q    <= bi_q + 1'b1;
							state_q <= S_BASE;
						end
					end else if (j_q + RW'(1) >= r_q) begin
						prime_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_SWAIT;
				S_SWAIT: if (mm_ctl.done) begin
					res_q   <= mm_p;
					j_q     <= j_q + 1'b1;
					state_q <= S_CHECK;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_IDLE && in_valid) begin
				x_q <= candidate;
				d_q <= candidate - W'(1);
				r_q <= '0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign is_prime  = prime_q;
endmodule
